// ----- hdl/ssht_pkg.sv -----
// shared types and constants for the segment snap hit test
`timescale 1ns / 1ps
`default_nettype none
package ssht_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // field widths
    localparam int COORD_W = 32;
    localparam int SNAP_W  = 31;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int SEL_W   = 11;

    // arithmetic widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int OPND_W  = 67;
    localparam int ACC_W   = 136;
    localparam int QUOT_W  = 34;
    localparam int REM_W   = 99;
    localparam int DIV_CNT_W = 6;

    localparam logic [SNAP_W-1:0]  SNAP_RESET  = SNAP_W'(327680);
    localparam logic [COUNT_W-1:0] COUNT_RESET = '0;

    // configuration register indexes
    localparam logic CFG_SNAP_DISTANCE = 1'b0;
    localparam logic CFG_SEGMENT_COUNT = 1'b1;

    // input actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_RD     = 9'b000000010,
        ST_CHK    = 9'b000000100,
        ST_MSTART = 9'b000001000,
        ST_MRUN   = 9'b000010000,
        ST_MEND   = 9'b000100000,
        ST_DRUN   = 9'b001000000,
        ST_DEND   = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    // multiply steps run on the shared multiply-accumulate unit
    typedef enum logic [3:0] {
        STEP_R2,
        STEP_AA,
        STEP_AB,
        STEP_CA,
        STEP_CB,
        STEP_TA,
        STEP_TB,
        STEP_RA,
        STEP_RB,
        STEP_NX,
        STEP_NY
    } step_t;

    // one table entry
    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      eligible;
    } entry_t;

endpackage
`default_nettype wire

// ----- hdl/segment_snap_hit_test.sv -----
// segment table with pointer snap search on one shared multiply and divide sequencer
// a load is taken while idle; a query first squares the snap radius, then scans the entries,
// passing over an ineligible one, testing an eligible one and dividing only for the match
// (bit-serial multiply-accumulate, one multiplier bit a cycle, plus two 34-step divides)
// throughput: one item at a time; ready only while idle, the result waits in the output register
// reset: synchronous active low; selection -1, snap distance 5.0, count 0, table not cleared
`timescale 1ns / 1ps
`default_nettype none
module segment_snap_hit_test #(
    parameter int TABLE_DEPTH = ssht_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // configuration
    input  wire                                  cfg_we,
    input  wire                                  cfg_index,
    input  wire  [ssht_pkg::SNAP_W-1:0]          cfg_wdata,
    // input words
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire                                  s_action,
    input  wire  [ssht_pkg::INDEX_W-1:0]         s_entry_index,
    input  wire  signed [ssht_pkg::COORD_W-1:0]  s_start_x,
    input  wire  signed [ssht_pkg::COORD_W-1:0]  s_start_y,
    input  wire  signed [ssht_pkg::COORD_W-1:0]  s_end_x,
    input  wire  signed [ssht_pkg::COORD_W-1:0]  s_end_y,
    input  wire                                  s_eligible,
    input  wire  signed [ssht_pkg::COORD_W-1:0]  s_pointer_x,
    input  wire  signed [ssht_pkg::COORD_W-1:0]  s_pointer_y,
    input  wire  signed [ssht_pkg::COORD_W-1:0]  s_pointer_z,
    // result words
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic                                 m_found,
    output logic signed [ssht_pkg::SEL_W-1:0]    m_selected_index,
    output logic signed [ssht_pkg::COORD_W-1:0]  m_snap_x,
    output logic signed [ssht_pkg::COORD_W-1:0]  m_snap_y,
    output logic signed [ssht_pkg::COORD_W-1:0]  m_snap_z
);
    import ssht_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

    // configuration registers
    logic [SNAP_W-1:0]  snap_radius_reg;
    logic [COUNT_W-1:0] seg_count_reg;

    // sequencer
    state_t state_reg, state_next;
    step_t  step_reg;

    // scan control
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] lim_reg;
    logic [CNT_W-1:0] idx_inc;
    logic             scan_last;

    // table memory
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic   load_ok;

    // query operands and intermediate results
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, wx_reg, wy_reg;
    logic signed [OPND_W-1:0]  a_reg, r2_reg, cr_reg, dt_reg;

    // multiply-accumulate unit
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  mcand_reg;
    logic [OPND_W-1:0]        mpl_reg;
    logic signed [OPND_W-1:0] op_x, op_y;
    logic                     op_neg, op_clear;
    logic signed [ACC_W-1:0]  x_ext;
    logic [OPND_W-1:0]        y_mag;
    logic [ACC_W-1:0]         acc_mag;

    // divide unit
    logic [REM_W-1:0]     rem_reg, dsh_reg;
    logic [QUOT_W-1:0]    q_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic                 qneg_reg;
    logic                 round_up;
    logic [QUOT_W:0]      q_round;
    logic signed [QUOT_W+1:0] base_ext, snap_sum;

    // result registers
    logic                      found_reg;
    logic signed [SEL_W-1:0]   sel_reg;
    logic signed [COORD_W-1:0] snap_x_reg, snap_y_reg, snap_z_reg;

    // pre-test of a candidate once the dot product is known
    logic pre_ok;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_found = found_reg;
    assign m_selected_index = sel_reg;
    assign m_snap_x = snap_x_reg;
    assign m_snap_y = snap_y_reg;
    assign m_snap_z = snap_z_reg;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign scan_last = (idx_inc >= lim_reg);
    assign load_ok   = (32'(s_entry_index) < 32'(TABLE_DEPTH));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_radius_reg <= SNAP_RESET;
            seg_count_reg   <= COUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SNAP_DISTANCE: snap_radius_reg <= cfg_wdata;
                CFG_SEGMENT_COUNT: seg_count_reg   <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // table write on load, registered read at the scan index
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_action == ACT_LOAD && load_ok) begin
            mem[ADDR_W'(s_entry_index)] <= '{sx: s_start_x, sy: s_start_y,
                                             ex: s_end_x, ey: s_end_y,
                                             eligible: s_eligible};
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    // operand select for the multiply-accumulate unit
    always_comb begin
        op_x     = '0;
        op_y     = '0;
        op_neg   = 1'b0;
        op_clear = 1'b0;
        case (step_reg)
            STEP_R2: begin
                op_x = OPND_W'(snap_radius_reg);
                op_y = OPND_W'(snap_radius_reg);
                op_clear = 1'b1;
            end
            STEP_AA: begin
                op_x = OPND_W'(dx_reg);
                op_y = OPND_W'(dx_reg);
                op_clear = 1'b1;
            end
            STEP_AB: begin
                op_x = OPND_W'(dy_reg);
                op_y = OPND_W'(dy_reg);
            end
            STEP_CA: begin
                op_x = OPND_W'(dx_reg);
                op_y = OPND_W'(wy_reg);
                op_clear = 1'b1;
            end
            STEP_CB: begin
                op_x = OPND_W'(dy_reg);
                op_y = OPND_W'(wx_reg);
                op_neg = 1'b1;
            end
            STEP_TA: begin
                op_x = OPND_W'(dx_reg);
                op_y = OPND_W'(wx_reg);
                op_clear = 1'b1;
            end
            STEP_TB: begin
                op_x = OPND_W'(dy_reg);
                op_y = OPND_W'(wy_reg);
            end
            STEP_RA: begin
                op_x = a_reg;
                op_y = r2_reg;
                op_clear = 1'b1;
            end
            STEP_RB: begin
                op_x = cr_reg;
                op_y = cr_reg;
                op_neg = 1'b1;
            end
            STEP_NX: begin
                op_x = dt_reg;
                op_y = OPND_W'(dx_reg);
                op_clear = 1'b1;
            end
            STEP_NY: begin
                op_x = dt_reg;
                op_y = OPND_W'(dy_reg);
                op_clear = 1'b1;
            end
            default: ;
        endcase
        x_ext = ACC_W'(op_x);
        y_mag = op_y[OPND_W-1] ? OPND_W'(-op_y) : op_y;
    end

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    // candidate must have nonzero length and a projection parameter in [0, 1]
    assign pre_ok = (a_reg != '0) && !acc_reg[ACC_W-1]
                    && (acc_reg <= ACC_W'(a_reg));

    // rounding and snap point from the divider result
    always_comb begin
        round_up = ({rem_reg[OPND_W-2:0], 1'b0} >= OPND_W'(a_reg));
        q_round  = (QUOT_W + 1)'(q_reg) + (QUOT_W + 1)'(round_up);
        base_ext = (step_reg == STEP_NX) ? (QUOT_W + 2)'(rd_data_reg.sx)
                                         : (QUOT_W + 2)'(rd_data_reg.sy);
        snap_sum = qneg_reg ? base_ext - $signed({1'b0, q_round})
                            : base_ext + $signed({1'b0, q_round});
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_action == ACT_QUERY) state_next = ST_MSTART;
            end
            ST_RD:     state_next = ST_CHK;
            ST_CHK: begin
                if (rd_data_reg.eligible) state_next = ST_MSTART;
                else if (scan_last)       state_next = ST_OUT;
                else                      state_next = ST_RD;
            end
            ST_MSTART: state_next = ST_MRUN;
            ST_MRUN: begin
                if (mpl_reg == '0) state_next = ST_MEND;
            end
            ST_MEND: begin
                case (step_reg)
                    STEP_R2: state_next = (lim_reg == '0) ? ST_OUT : ST_RD;
                    STEP_TB: begin
                        if (pre_ok)         state_next = ST_MSTART;
                        else if (scan_last) state_next = ST_OUT;
                        else                state_next = ST_RD;
                    end
                    STEP_RB: begin
                        if (!acc_reg[ACC_W-1]) state_next = ST_MSTART;
                        else if (scan_last)    state_next = ST_OUT;
                        else                   state_next = ST_RD;
                    end
                    STEP_NX, STEP_NY: state_next = ST_DRUN;
                    default: state_next = ST_MSTART;
                endcase
            end
            ST_DRUN: begin
                if (dcnt_reg == DIV_LAST) state_next = ST_DEND;
            end
            ST_DEND: state_next = (step_reg == STEP_NX) ? ST_MSTART : ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // selection register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= -SEL_W'(1);
        end else if (state_reg == ST_MEND) begin
            if ((step_reg == STEP_TB && !pre_ok)
                || (step_reg == STEP_RB && acc_reg[ACC_W-1])) begin
                sel_reg <= -SEL_W'(1);
            end else if (step_reg == STEP_RB) begin
                sel_reg <= SEL_W'(idx_reg);
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_action == ACT_QUERY) begin
                    px_reg     <= s_pointer_x;
                    py_reg     <= s_pointer_y;
                    pz_reg     <= s_pointer_z;
                    idx_reg    <= '0;
                    lim_reg    <= (32'(seg_count_reg) > 32'(TABLE_DEPTH))
                                  ? CNT_W'(TABLE_DEPTH) : CNT_W'(seg_count_reg);
                    step_reg   <= STEP_R2;
                    found_reg  <= 1'b0;
                    snap_x_reg <= '0;
                    snap_y_reg <= '0;
                    snap_z_reg <= '0;
                end
            end
            ST_CHK: begin
                if (rd_data_reg.eligible) begin
                    dx_reg   <= DIFF_W'(rd_data_reg.ex) - DIFF_W'(rd_data_reg.sx);
                    dy_reg   <= DIFF_W'(rd_data_reg.ey) - DIFF_W'(rd_data_reg.sy);
                    wx_reg   <= DIFF_W'(px_reg) - DIFF_W'(rd_data_reg.sx);
                    wy_reg   <= DIFF_W'(py_reg) - DIFF_W'(rd_data_reg.sy);
                    step_reg <= STEP_AA;
                end else begin
                    idx_reg <= idx_inc;
                end
            end
            ST_MSTART: begin
                if (op_clear) acc_reg <= '0;
                mcand_reg <= (op_y[OPND_W-1] ^ op_neg) ? -x_ext : x_ext;
                mpl_reg   <= y_mag;
            end
            ST_MRUN: begin
                if (mpl_reg != '0) begin
                    if (mpl_reg[0]) acc_reg <= acc_reg + mcand_reg;
                    mcand_reg <= mcand_reg <<< 1;
                    mpl_reg   <= mpl_reg >> 1;
                end
            end
            ST_MEND: begin
                case (step_reg)
                    STEP_R2: r2_reg <= OPND_W'(acc_reg);
                    STEP_AA: step_reg <= STEP_AB;
                    STEP_AB: begin
                        a_reg    <= OPND_W'(acc_reg);
                        step_reg <= STEP_CA;
                    end
                    STEP_CA: step_reg <= STEP_CB;
                    STEP_CB: begin
                        cr_reg   <= OPND_W'(acc_reg);
                        step_reg <= STEP_TA;
                    end
                    STEP_TA: step_reg <= STEP_TB;
                    STEP_TB: begin
                        dt_reg <= OPND_W'(acc_reg);
                        if (pre_ok) step_reg <= STEP_RA;
                        else        idx_reg  <= idx_inc;
                    end
                    STEP_RA: step_reg <= STEP_RB;
                    STEP_RB: begin
                        if (!acc_reg[ACC_W-1]) begin
                            found_reg <= 1'b1;
                            step_reg  <= STEP_NX;
                        end else begin
                            idx_reg <= idx_inc;
                        end
                    end
                    STEP_NX, STEP_NY: begin
                        // start the divide of |dot * d| by the squared length
                        rem_reg  <= REM_W'(acc_mag);
                        qneg_reg <= acc_reg[ACC_W-1];
                        dsh_reg  <= {a_reg[OPND_W-2:0], (REM_W - OPND_W + 1)'(0)};
                        q_reg    <= '0;
                        dcnt_reg <= '0;
                    end
                    default: ;
                endcase
            end
            ST_DRUN: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[QUOT_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[QUOT_W-2:0], 1'b0};
                end
                dsh_reg  <= dsh_reg >> 1;
                dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
            end
            ST_DEND: begin
                if (step_reg == STEP_NX) begin
                    snap_x_reg <= snap_sum[COORD_W-1:0];
                    step_reg   <= STEP_NY;
                end else begin
                    snap_y_reg <= snap_sum[COORD_W-1:0];
                    snap_z_reg <= pz_reg;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while a result is pending");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_snap_x == '0 && m_snap_y == '0 && m_snap_z == '0))
        else $error("snap point nonzero without a match");

    a_found_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> !m_selected_index[SEL_W-1])
        else $error("match reported with no selection");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEND) |-> (rem_reg < REM_W'(a_reg)))
        else $error("divide remainder not below divisor");

endmodule
`default_nettype wire

// ----- tb/sv/tb_segment_snap_hit_test.sv -----
// testbench for the segment snap hit test: directed and random words checked against a predictor
`timescale 1ns / 1ps
module tb_segment_snap_hit_test;
    import ssht_pkg::*;

    // small table so a full fill stays short; loads above it are dropped
    localparam int DEPTH      = 64;
    localparam int STALL_LIMIT = 200000;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic                      action;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
        logic                      eligible;
        logic signed [COORD_W-1:0] pointer_x, pointer_y, pointer_z;
    } word_t;

    typedef struct {
        logic                      found;
        logic signed [SEL_W-1:0]   sel;
        logic signed [COORD_W-1:0] snap_x, snap_y, snap_z;
    } hit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_SNAP_DISTANCE;
    logic [SNAP_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = ACT_LOAD;
    logic [INDEX_W-1:0] s_entry_index = '0;
    logic signed [COORD_W-1:0] s_start_x = '0, s_start_y = '0, s_end_x = '0, s_end_y = '0;
    logic s_eligible = 1'b0;
    logic signed [COORD_W-1:0] s_pointer_x = '0, s_pointer_y = '0, s_pointer_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_found;
    logic signed [SEL_W-1:0] m_selected_index;
    logic signed [COORD_W-1:0] m_snap_x, m_snap_y, m_snap_z;

    segment_snap_hit_test #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_entry_index(s_entry_index), .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_end_x(s_end_x), .s_end_y(s_end_y), .s_eligible(s_eligible),
        .s_pointer_x(s_pointer_x), .s_pointer_y(s_pointer_y), .s_pointer_z(s_pointer_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_selected_index(m_selected_index), .m_snap_x(m_snap_x), .m_snap_y(m_snap_y),
        .m_snap_z(m_snap_z)
    );

    always #5 aclk = ~aclk;

    // predictor state
    entry_t              seg_table [DEPTH];
    logic signed [SEL_W-1:0] cur_sel;
    logic [SNAP_W-1:0]   snap_radius;
    logic [COUNT_W-1:0]  seg_count;
    hit_t                pending_hits [$];

    int  errors = 0;
    bit  idle_on = 1'b1;
    int  hold_left = 0;
    int  rx_burst = 0;
    int  quiet_cycles = 0;
    bit  table_full = 1'b0;

    // start + round(num / den), ties away from zero
    function automatic logic signed [COORD_W-1:0] project_axis(longint start, wide_t num,
                                                               wide_t den);
        bit    neg;
        wide_t mag, q, rem;
        logic [35:0] q36;
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        rem = mag - q * den;
        if (rem * 2 >= den) q = q + 1;
        q36 = q[35:0];
        return neg ? COORD_W'(start - longint'(q36)) : COORD_W'(start + longint'(q36));
    endfunction

    // scan the table for the first eligible segment near the pointer
    function automatic hit_t predict_snap(word_t w);
        hit_t  h;
        wide_t r2, dx, dy, wx, wy, a, cr, dt;
        int    n;
        h.found = 1'b0;
        h.snap_x = '0;
        h.snap_y = '0;
        h.snap_z = '0;
        r2 = wide_t'(snap_radius);
        r2 = r2 * r2;
        n = (seg_count > DEPTH) ? DEPTH : int'(seg_count);
        for (int i = 0; i < n; i++) begin
            if (!seg_table[i].eligible) continue;
            dx = longint'(seg_table[i].ex) - longint'(seg_table[i].sx);
            dy = longint'(seg_table[i].ey) - longint'(seg_table[i].sy);
            wx = longint'(w.pointer_x) - longint'(seg_table[i].sx);
            wy = longint'(w.pointer_y) - longint'(seg_table[i].sy);
            a  = dx * dx + dy * dy;
            cr = dx * wy - dy * wx;
            dt = dx * wx + dy * wy;
            if (a != 0 && cr * cr <= a * r2 && dt >= 0 && dt <= a) begin
                cur_sel = SEL_W'(i);
                h.found = 1'b1;
                h.snap_x = project_axis(seg_table[i].sx, dt * dx, a);
                h.snap_y = project_axis(seg_table[i].sy, dt * dy, a);
                h.snap_z = w.pointer_z;
                break;
            end
            cur_sel = -1;
        end
        h.sel = cur_sel;
        return h;
    endfunction

    // drive one word and update the predictor when it is taken
    task automatic send_word(word_t w);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action = w.action;
        s_entry_index = w.entry_index;
        s_start_x = w.start_x;
        s_start_y = w.start_y;
        s_end_x = w.end_x;
        s_end_y = w.end_y;
        s_eligible = w.eligible;
        s_pointer_x = w.pointer_x;
        s_pointer_y = w.pointer_y;
        s_pointer_z = w.pointer_z;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (w.action == ACT_LOAD) begin
            // loads beyond the table are dropped
            if (int'(w.entry_index) < DEPTH) begin
                seg_table[w.entry_index] = '{w.start_x, w.start_y, w.end_x, w.end_y,
                                             w.eligible};
            end
        end else begin
            pending_hits.push_back(predict_snap(w));
        end
        @(negedge aclk);
    endtask

    task automatic load_seg(int idx, longint sx, longint sy, longint ex, longint ey, bit elig);
        word_t w;
        w = '{ACT_LOAD, INDEX_W'(idx), COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey),
              elig, $urandom, $urandom, $urandom};
        send_word(w);
    endtask

    task automatic query_at(longint px, longint py, longint pz);
        word_t w;
        w = '{ACT_QUERY, INDEX_W'($urandom), $urandom, $urandom, $urandom, $urandom,
              1'($urandom), COORD_W'(px), COORD_W'(py), COORD_W'(pz)};
        send_word(w);
    endtask

    // wait for every result, then for the block to go idle
    task automatic settle();
        s_valid = 1'b0;
        while (pending_hits.size() != 0) @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned data);
        settle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = SNAP_W'(data);
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_SNAP_DISTANCE) snap_radius = SNAP_W'(data);
        else seg_count = COUNT_W'(data);
    endtask

    function automatic longint rand_coord();
        if ($urandom_range(0, 3) == 0) return longint'($signed(32'($urandom)));
        return longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    endfunction

    // pointer near stored entry k: a point along it plus a small offset
    task automatic query_near(int k);
        longint sx, sy, ex, ey, px, py;
        longint f;
        sx = seg_table[k].sx;
        sy = seg_table[k].sy;
        ex = seg_table[k].ex;
        ey = seg_table[k].ey;
        f = longint'($urandom_range(0, 70000)) - 2000;
        px = sx + (((ex - sx) * f) >>> 16) + longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        py = sy + (((ey - sy) * f) >>> 16) + longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        query_at(px, py, rand_coord());
    endtask

    // defaults, segment shapes, both ends, snap distance extremes, kept selection
    task automatic test_directed();
        query_at(0, 0, 7);
        load_seg(0, 0, 0, 10 << 16, 10 << 16, 1'b0);
        load_seg(1, 0, 0, 10 << 16, 0, 1'b1);
        load_seg(2, 3 << 16, 3 << 16, 3 << 16, 3 << 16, 1'b1);
        load_seg(3, -2147483648, -2147483648, 2147483647, 2147483647, 1'b1);
        for (int i = 4; i < 16; i++)
            load_seg(i, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
        write_reg(CFG_SEGMENT_COUNT, 4);
        query_at(5 << 16, 3 << 16, -5);
        query_at(0, 0, 2147483647);
        query_at(10 << 16, 0, -2147483648);
        query_at(11 << 16, 0, 1);
        query_at(3 << 16, 3 << 16, 2);
        query_at(-2147483648, -2147483648, 3);
        query_at(2147483647, 2147483647, 4);
        query_at(2147483647, -2147483648, 5);
        // only the ineligible entry is scanned, the selection stays
        write_reg(CFG_SEGMENT_COUNT, 1);
        query_at(1 << 16, 1 << 16, 6);
        write_reg(CFG_SNAP_DISTANCE, 0);
        write_reg(CFG_SEGMENT_COUNT, 16);
        query_at(4 << 16, 0, 8);
        query_at(4 << 16, 1, 9);
        write_reg(CFG_SNAP_DISTANCE, 32'h7FFF_FFFF);
        query_at(-7 << 16, 1 << 30, 10);
        query_at(rand_coord(), rand_coord(), 11);
    endtask

    // fill the whole table and scan it, also with a count beyond the table
    task automatic test_full_table();
        write_reg(CFG_SNAP_DISTANCE, 327680);
        for (int i = 16; i < DEPTH; i++)
            load_seg(i, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(0, 99) == 0);
        // load beyond the table is dropped
        load_seg(DEPTH + 3, 0, 0, 1 << 16, 0, 1'b1);
        table_full = 1'b1;
        write_reg(CFG_SEGMENT_COUNT, 1024);
        query_near(DEPTH - 1);
        query_at(rand_coord(), rand_coord(), rand_coord());
        write_reg(CFG_SEGMENT_COUNT, 32'h7FF);
        query_near(DEPTH / 2);
        write_reg(CFG_SEGMENT_COUNT, 16);
    endtask

    // receiver holds off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        hold_left = 400;
        for (int i = 0; i < 5; i++) query_near($urandom_range(0, 15));
        settle();
        query_near(1);
    endtask

    task automatic random_word();
        int k;
        if ($urandom_range(0, 9) < 3) begin
            k = (table_full && $urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH - 1)
                                                         : $urandom_range(0, 15);
            load_seg(k, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     k < 16 ? $urandom_range(0, 2) != 0 : $urandom_range(0, 19) == 0);
        end else if ($urandom_range(0, 5) == 0) begin
            query_at(rand_coord(), rand_coord(), rand_coord());
        end else begin
            query_near($urandom_range(0, 15));
        end
    endtask

    // random words with the settings changed between phases
    task automatic test_random();
        int unsigned d;
        for (int i = 0; i < 200; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: d = 0;
                    1: d = 32'h7FFF_FFFF;
                    2: d = $urandom & 32'h7FFF_FFFF;
                    default: d = $urandom_range(0, 1 << 20);
                endcase
                write_reg(CFG_SNAP_DISTANCE, d);
                write_reg(CFG_SEGMENT_COUNT,
                          $urandom_range(0, 5) == 0 ? 1024 : $urandom_range(0, 16));
            end
            if (i == 170) idle_on = 1'b0;
            random_word();
        end
    endtask

    // result side ready with random stall bursts and a long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (rx_burst > 0) begin
                m_ready = 1'b0;
                rx_burst--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                rx_burst = $urandom_range(1, 12) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result word sel %0d", $realtime, m_selected_index);
                errors++;
            end else begin
                e = pending_hits.pop_front();
                if (m_found !== e.found) begin
                    $display("%0t: found exp %0b got %0b", $realtime, e.found, m_found);
                    errors++;
                end
                if (m_selected_index !== e.sel) begin
                    $display("%0t: selected_index exp %0d got %0d", $realtime, e.sel,
                             m_selected_index);
                    errors++;
                end
                if (m_snap_x !== e.snap_x) begin
                    $display("%0t: snap_x exp %h got %h", $realtime, e.snap_x, m_snap_x);
                    errors++;
                end
                if (m_snap_y !== e.snap_y) begin
                    $display("%0t: snap_y exp %h got %h", $realtime, e.snap_y, m_snap_y);
                    errors++;
                end
                if (m_snap_z !== e.snap_z) begin
                    $display("%0t: snap_z exp %h got %h", $realtime, e.snap_z, m_snap_z);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        cur_sel = -1;
        snap_radius = SNAP_RESET;
        seg_count = COUNT_RESET;
        for (int i = 0; i < DEPTH; i++) seg_table[i] = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        settle();
        repeat (50) @(negedge aclk);
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
